// ===== hw/rtl/mbae_pkg.sv =====
`default_nettype none

package mbae_pkg;

    localparam int unsigned MAX_WIDTH  = 4096;
    localparam int unsigned MAX_HEIGHT = 4096;

    localparam int unsigned PIX_W  = 8;
    localparam int unsigned EXP_W  = 14;
    localparam int unsigned MEAN_W = 16;
    localparam int unsigned GAIN_W = 16;
    localparam int unsigned TGT_W  = 8;
    localparam int unsigned DIM_W  = 13;
    localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
    localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT);
    localparam int unsigned HALF_W = ROW_W;
    localparam int unsigned SUM_W  = 31;
    localparam int unsigned AREA_W = COL_W + HALF_W;
    localparam int unsigned PH_W   = 3;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam int unsigned DIV_W = (AREA_W > MEAN_W) ? AREA_W : MEAN_W;
    localparam int unsigned QUO_W = MEAN_W;
    localparam int unsigned CNT_W = $clog2(QUO_W + 1);

    localparam int unsigned PROD1_W = GAIN_W + EXP_W;
    localparam int unsigned PROD_W  = PROD1_W + MEAN_W;
    localparam int unsigned GAIN_FRAC = 12;
    localparam int unsigned C_W       = PROD_W - GAIN_FRAC + 1;
    localparam int unsigned EXP_QUO_W = EXP_W;

    localparam logic [EXP_W-1:0]  EXP_MIN      = EXP_W'(1);
    localparam logic [EXP_W-1:0]  EXP_MAX      = EXP_W'(10000);
    localparam logic [EXP_W-1:0]  EXP_RESET    = EXP_W'(156);
    localparam logic [PH_W-1:0]   PHASE_LAST   = PH_W'(4);
    localparam logic [TGT_W-1:0]  TGT_RESET    = TGT_W'(128);
    localparam logic [GAIN_W-1:0] GAIN_RESET   = GAIN_W'(4096);
    localparam logic [DIM_W-1:0]  WIDTH_RESET  = DIM_W'(600);
    localparam logic [DIM_W-1:0]  HEIGHT_RESET = DIM_W'(400);
    localparam logic [DIM_W-1:0]  WIDTH_MIN    = DIM_W'(1);
    localparam logic [DIM_W-1:0]  HEIGHT_MIN   = DIM_W'(2);
    localparam logic [DIM_W-1:0]  WIDTH_MAX    = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0]  HEIGHT_MAX   = DIM_W'(MAX_HEIGHT);
    localparam logic [SUM_W-1:0]  SUM_MAX      = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0]  MEAN_STEPS   = CNT_W'(QUO_W);
    localparam logic [CNT_W-1:0]  EXP_STEPS    = CNT_W'(EXP_QUO_W);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AUTO_ENABLE       = 3'd0,
        REG_MANUAL_EXPOSURE   = 3'd1,
        REG_TARGET_BRIGHTNESS = 3'd2,
        REG_EXPOSURE_GAIN     = 3'd3,
        REG_SOURCE_SELECT     = 3'd4,
        REG_FRAME_WIDTH       = 3'd5,
        REG_FRAME_HEIGHT      = 3'd6
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AREA,
        S_MCHK,
        S_MDIV,
        S_EMUL1,
        S_EMUL2,
        S_ECEIL,
        S_ECHK,
        S_EDIV,
        S_EFIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic pix_take;
        logic out_plain;
        logic area_load;
        logic mean_chk;
        logic mean_step;
        logic exp_mul1;
        logic exp_mul2;
        logic exp_ceil;
        logic exp_chk;
        logic exp_step;
        logic exp_fin;
        logic out_upd;
    } t_cmd;

    typedef struct packed {
        logic auto_due;
        logic out_full;
        logic div_last;
        logic mean_zero;
        logic mean_sat;
        logic exp_ovf;
    } t_status;

endpackage

`default_nettype wire

// ===== hw/rtl/mbae_if.sv =====
`default_nettype none

interface mbae_pix_if;
    logic                           valid;
    logic                           ready;
    logic [mbae_pkg::PIX_W-1:0]     ir_pixel;
    logic [mbae_pkg::PIX_W-1:0]     color_pixel;
    logic                           frame_end;

    modport source (output valid, output ir_pixel, output color_pixel, output frame_end,
                    input ready);
    modport sink   (input valid, input ir_pixel, input color_pixel, input frame_end,
                    output ready);
endinterface

interface mbae_res_if;
    logic                           valid;
    logic                           ready;
    logic [mbae_pkg::EXP_W-1:0]     exposure_out;
    logic                           was_updated;
    logic [mbae_pkg::MEAN_W-1:0]    mean_level;

    modport source (output valid, output exposure_out, output was_updated,
                    output mean_level, input ready);
    modport sink   (input valid, input exposure_out, input was_updated,
                    input mean_level, output ready);
endinterface

interface mbae_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [mbae_pkg::CFG_IDX_W-1:0]     index;
    logic [mbae_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mean_brightness_auto_exposure.sv =====
// Pixel beats are taken one per cycle while the controller is idle (a frame-end beat also waits
// while the previous result beat is not yet accepted); a frame-end beat with no update gives its
// result beat in the cycle after acceptance. An updating frame end computes the mean and exposure
// with one shared 1-bit-per-cycle divider; no pixel beat is taken until the result beat.
// Reset (synchronous, active low) restores the register defaults, exposure 156, phase 0,
// and clears the frame counters, the pixel sum and the result valid flag.
`default_nettype none

module mean_brightness_auto_exposure (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mbae_pix_if.sink   i_pix,
    mbae_res_if.source o_res,
    mbae_cfg_if.sink   i_cfg
);

    mbae_pkg::t_cmd    cmd;
    mbae_pkg::t_status status;
    logic              pix_ready;

    assign i_pix.ready = pix_ready;
    assign i_cfg.ready = 1'b1;

    mbae_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pix.valid),
        .i_frame_end (i_pix.frame_end),
        .o_in_ready  (pix_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    mbae_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_ir_pixel     (i_pix.ir_pixel),
        .i_color_pixel  (i_pix.color_pixel),
        .i_frame_end    (i_pix.frame_end),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .i_out_ready    (o_res.ready),
        .o_out_valid    (o_res.valid),
        .o_exposure_out (o_res.exposure_out),
        .o_was_updated  (o_res.was_updated),
        .o_mean_level   (o_res.mean_level)
    );

    a_exp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.exposure_out >= mbae_pkg::EXP_MIN)
                     && (o_res.exposure_out <= mbae_pkg::EXP_MAX))
        else $error("exposure beat out of range");

    a_mean_plain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.was_updated) |-> (o_res.mean_level == '0))
        else $error("mean set on a frame without update");

    a_plain_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && pix_ready && i_pix.frame_end && !status.auto_due) |=> o_res.valid)
        else $error("frame end without update gave no result beat");

    a_busy_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.mean_step || cmd.exp_step) |-> !pix_ready)
        else $error("pixel beat taken during division");

endmodule

`default_nettype wire

// ===== hw/rtl/mbae_ctrl.sv =====
`default_nettype none

module mbae_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_frame_end,
    output logic                   o_in_ready,
    input  wire mbae_pkg::t_status i_status,
    output mbae_pkg::t_cmd         o_cmd
);

    mbae_pkg::t_state r_state;
    mbae_pkg::t_state n_state;
    logic             take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mbae_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        take       = 1'b0;
        unique case (r_state)
            mbae_pkg::S_IDLE: begin
                o_in_ready     = !(i_status.out_full && i_frame_end);
                take           = i_in_valid && o_in_ready;
                o_cmd.pix_take = take;
                if (take && i_frame_end) begin
                    if (i_status.auto_due) begin
                        n_state = mbae_pkg::S_AREA;
                    end else begin
                        o_cmd.out_plain = 1'b1;
                    end
                end
            end
            mbae_pkg::S_AREA: begin
                o_cmd.area_load = 1'b1;
                n_state         = mbae_pkg::S_MCHK;
            end
            mbae_pkg::S_MCHK: begin
                o_cmd.mean_chk = 1'b1;
                n_state = i_status.mean_sat ? mbae_pkg::S_EMUL1 : mbae_pkg::S_MDIV;
            end
            mbae_pkg::S_MDIV: begin
                o_cmd.mean_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = mbae_pkg::S_EMUL1;
                end
            end
            mbae_pkg::S_EMUL1: begin
                o_cmd.exp_mul1 = 1'b1;
                n_state = i_status.mean_zero ? mbae_pkg::S_OUT : mbae_pkg::S_EMUL2;
            end
            mbae_pkg::S_EMUL2: begin
                o_cmd.exp_mul2 = 1'b1;
                n_state        = mbae_pkg::S_ECEIL;
            end
            mbae_pkg::S_ECEIL: begin
                o_cmd.exp_ceil = 1'b1;
                n_state        = mbae_pkg::S_ECHK;
            end
            mbae_pkg::S_ECHK: begin
                o_cmd.exp_chk = 1'b1;
                n_state = i_status.exp_ovf ? mbae_pkg::S_OUT : mbae_pkg::S_EDIV;
            end
            mbae_pkg::S_EDIV: begin
                o_cmd.exp_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = mbae_pkg::S_EFIN;
                end
            end
            mbae_pkg::S_EFIN: begin
                o_cmd.exp_fin = 1'b1;
                n_state       = mbae_pkg::S_OUT;
            end
            mbae_pkg::S_OUT: begin
                o_cmd.out_upd = 1'b1;
                n_state       = mbae_pkg::S_IDLE;
            end
            default: begin
                n_state = mbae_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mbae_dp.sv =====
`default_nettype none

module mbae_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire mbae_pkg::t_cmd                      i_cmd,
    output mbae_pkg::t_status                        o_status,
    input  wire logic [mbae_pkg::PIX_W-1:0]          i_ir_pixel,
    input  wire logic [mbae_pkg::PIX_W-1:0]          i_color_pixel,
    input  wire logic                                i_frame_end,
    input  wire logic                                i_cfg_we,
    input  wire logic [mbae_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [mbae_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                                i_out_ready,
    output logic                                     o_out_valid,
    output logic [mbae_pkg::EXP_W-1:0]               o_exposure_out,
    output logic                                     o_was_updated,
    output logic [mbae_pkg::MEAN_W-1:0]              o_mean_level
);

    // configuration
    logic                            r_auto;
    logic [mbae_pkg::EXP_W-1:0]      r_manual;
    logic [mbae_pkg::TGT_W-1:0]      r_target;
    logic [mbae_pkg::GAIN_W-1:0]     r_gain;
    logic                            r_src;
    logic [mbae_pkg::DIM_W-1:0]      r_fw;
    logic [mbae_pkg::DIM_W-1:0]      r_fh;

    // frame state
    logic [mbae_pkg::EXP_W-1:0]      r_exp;
    logic [mbae_pkg::PH_W-1:0]       r_phase;
    logic [mbae_pkg::COL_W-1:0]      r_col;
    logic [mbae_pkg::ROW_W-1:0]      r_row;
    logic [mbae_pkg::SUM_W-1:0]      r_sum;

    // arithmetic
    logic [mbae_pkg::AREA_W-1:0]     r_area;
    logic [mbae_pkg::MEAN_W-1:0]     r_mean;
    logic [mbae_pkg::PROD1_W-1:0]    r_prod1;
    logic [mbae_pkg::PROD_W-1:0]     r_prod;
    logic [mbae_pkg::C_W-1:0]        r_c;
    logic                            r_neg;
    logic [mbae_pkg::MEAN_W-1:0]     r_mag;
    logic [mbae_pkg::DIV_W-1:0]      r_rem;
    logic [mbae_pkg::DIV_W-1:0]      r_div;
    logic [mbae_pkg::QUO_W-1:0]      r_quo;
    logic [mbae_pkg::CNT_W-1:0]      r_cnt;

    // result
    logic                            r_out_valid;
    logic [mbae_pkg::EXP_W-1:0]      r_out_exp;
    logic                            r_out_upd;
    logic [mbae_pkg::MEAN_W-1:0]     r_out_mean;

    logic                            n_auto;
    logic [mbae_pkg::EXP_W-1:0]      n_manual;
    logic                            cfg_hit;
    logic [mbae_pkg::EXP_W-1:0]      man_clamped;
    logic [mbae_pkg::DIM_W-1:0]      w_eff;
    logic [mbae_pkg::DIM_W-1:0]      h_eff;
    logic [mbae_pkg::HALF_W-1:0]     half;
    logic [mbae_pkg::PIX_W-1:0]      pix;
    logic [mbae_pkg::SUM_W:0]        sum_add;
    logic [mbae_pkg::COL_W:0]        col_inc;
    logic [mbae_pkg::DIV_W:0]        div_t;
    logic                            div_ge;
    logic [mbae_pkg::DIV_W-1:0]      n_rem;
    logic [mbae_pkg::QUO_W-1:0]      n_quo;
    logic [mbae_pkg::MEAN_W-1:0]     tgt_q;
    logic [mbae_pkg::PROD_W:0]       prod_up;
    logic [mbae_pkg::EXP_QUO_W-1:0]  q_exp;
    logic [mbae_pkg::EXP_W:0]        pos_sum;
    logic [mbae_pkg::EXP_W:0]        neg_q;
    logic [mbae_pkg::EXP_W-1:0]      n_exp_fin;

    always_comb begin
        n_auto   = r_auto;
        n_manual = r_manual;
        cfg_hit  = 1'b0;
        if (i_cfg_we) begin
            unique case (mbae_pkg::t_reg_idx'(i_cfg_index))
                mbae_pkg::REG_AUTO_ENABLE: begin
                    n_auto  = i_cfg_data[0];
                    cfg_hit = 1'b1;
                end
                mbae_pkg::REG_MANUAL_EXPOSURE: begin
                    n_manual = i_cfg_data[mbae_pkg::EXP_W-1:0];
                    cfg_hit  = 1'b1;
                end
                mbae_pkg::REG_TARGET_BRIGHTNESS,
                mbae_pkg::REG_EXPOSURE_GAIN,
                mbae_pkg::REG_SOURCE_SELECT,
                mbae_pkg::REG_FRAME_WIDTH,
                mbae_pkg::REG_FRAME_HEIGHT: begin
                    cfg_hit = 1'b1;
                end
                default: begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
        if (n_manual < mbae_pkg::EXP_MIN) begin
            man_clamped = mbae_pkg::EXP_MIN;
        end else if (n_manual > mbae_pkg::EXP_MAX) begin
            man_clamped = mbae_pkg::EXP_MAX;
        end else begin
            man_clamped = n_manual;
        end
    end

    always_comb begin
        if (r_fw < mbae_pkg::WIDTH_MIN) begin
            w_eff = mbae_pkg::WIDTH_MIN;
        end else if (r_fw > mbae_pkg::WIDTH_MAX) begin
            w_eff = mbae_pkg::WIDTH_MAX;
        end else begin
            w_eff = r_fw;
        end
        if (r_fh < mbae_pkg::HEIGHT_MIN) begin
            h_eff = mbae_pkg::HEIGHT_MIN;
        end else if (r_fh > mbae_pkg::HEIGHT_MAX) begin
            h_eff = mbae_pkg::HEIGHT_MAX;
        end else begin
            h_eff = r_fh;
        end
        half = h_eff[mbae_pkg::DIM_W-1:1];
    end

    assign pix     = r_src ? i_ir_pixel : i_color_pixel;
    assign sum_add = {1'b0, r_sum} + (mbae_pkg::SUM_W + 1)'(pix);
    assign col_inc = {1'b0, r_col} + (mbae_pkg::COL_W + 1)'(1);

    // shared restoring divider step
    assign div_t  = {r_rem, r_quo[mbae_pkg::QUO_W-1]};
    assign div_ge = div_t >= {1'b0, r_div};
    assign n_rem  = div_ge ? mbae_pkg::DIV_W'(div_t - {1'b0, r_div})
                           : div_t[mbae_pkg::DIV_W-1:0];
    assign n_quo  = {r_quo[mbae_pkg::QUO_W-2:0], div_ge};

    assign tgt_q   = {r_target, {(mbae_pkg::MEAN_W - mbae_pkg::TGT_W){1'b0}}};
    assign prod_up = {1'b0, r_prod} + (mbae_pkg::PROD_W + 1)'((1 << mbae_pkg::GAIN_FRAC) - 1);

    always_comb begin
        q_exp   = r_quo[mbae_pkg::EXP_QUO_W-1:0];
        pos_sum = {1'b0, r_exp} + (mbae_pkg::EXP_W + 1)'(q_exp);
        neg_q   = (mbae_pkg::EXP_W + 1)'(q_exp) + (mbae_pkg::EXP_W + 1)'(r_rem != '0);
        if (r_neg) begin
            if (neg_q >= {1'b0, r_exp}) begin
                n_exp_fin = mbae_pkg::EXP_MIN;
            end else begin
                n_exp_fin = r_exp - neg_q[mbae_pkg::EXP_W-1:0];
            end
        end else begin
            if (pos_sum > {1'b0, mbae_pkg::EXP_MAX}) begin
                n_exp_fin = mbae_pkg::EXP_MAX;
            end else begin
                n_exp_fin = pos_sum[mbae_pkg::EXP_W-1:0];
            end
        end
    end

    // configuration registers and exposure
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto   <= 1'b1;
            r_manual <= mbae_pkg::EXP_RESET;
            r_target <= mbae_pkg::TGT_RESET;
            r_gain   <= mbae_pkg::GAIN_RESET;
            r_src    <= 1'b0;
            r_fw     <= mbae_pkg::WIDTH_RESET;
            r_fh     <= mbae_pkg::HEIGHT_RESET;
            r_exp    <= mbae_pkg::EXP_RESET;
        end else begin
            r_auto   <= n_auto;
            r_manual <= n_manual;
            if (i_cfg_we) begin
                unique case (mbae_pkg::t_reg_idx'(i_cfg_index))
                    mbae_pkg::REG_TARGET_BRIGHTNESS: begin
                        r_target <= i_cfg_data[mbae_pkg::TGT_W-1:0];
                    end
                    mbae_pkg::REG_EXPOSURE_GAIN: begin
                        r_gain <= i_cfg_data[mbae_pkg::GAIN_W-1:0];
                    end
                    mbae_pkg::REG_SOURCE_SELECT: begin
                        r_src <= i_cfg_data[0];
                    end
                    mbae_pkg::REG_FRAME_WIDTH: begin
                        r_fw <= i_cfg_data[mbae_pkg::DIM_W-1:0];
                    end
                    mbae_pkg::REG_FRAME_HEIGHT: begin
                        r_fh <= i_cfg_data[mbae_pkg::DIM_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            priority if (cfg_hit && !n_auto) begin
                r_exp <= man_clamped;
            end else if (i_cmd.exp_mul1 && r_mean == '0) begin
                r_exp <= mbae_pkg::EXP_MAX;
            end else if (i_cmd.exp_chk && o_status.exp_ovf) begin
                r_exp <= r_neg ? mbae_pkg::EXP_MIN : mbae_pkg::EXP_MAX;
            end else if (i_cmd.exp_fin) begin
                r_exp <= n_exp_fin;
            end else begin
                r_exp <= r_exp;
            end
        end
    end

    // frame position, sum and phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_sum   <= '0;
        end else begin
            if (i_cmd.pix_take) begin
                if (r_row < half) begin
                    r_sum <= sum_add[mbae_pkg::SUM_W] ? mbae_pkg::SUM_MAX
                                                      : sum_add[mbae_pkg::SUM_W-1:0];
                end
                if (i_frame_end) begin
                    r_col <= '0;
                    r_row <= '0;
                    if (r_auto) begin
                        r_phase <= (r_phase == mbae_pkg::PHASE_LAST) ? '0
                                                                     : r_phase + 1'b1;
                    end
                end else if (col_inc >= (mbae_pkg::COL_W + 1)'(w_eff)) begin
                    r_col <= '0;
                    if (r_row != '1) begin
                        r_row <= r_row + 1'b1;
                    end
                end else begin
                    r_col <= col_inc[mbae_pkg::COL_W-1:0];
                end
            end
            if (i_cmd.out_plain || i_cmd.out_upd) begin
                r_sum <= '0;
            end
        end
    end

    // mean and exposure arithmetic
    always_ff @(posedge i_clk) begin
        if (i_cmd.area_load) begin
            r_area <= mbae_pkg::AREA_W'(w_eff * half);
        end
        if (i_cmd.mean_chk) begin
            if (o_status.mean_sat) begin
                r_mean <= '1;
            end else begin
                r_rem <= mbae_pkg::DIV_W'(r_sum[mbae_pkg::SUM_W-1:8]);
                r_quo <= {r_sum[7:0], 8'h00};
                r_div <= mbae_pkg::DIV_W'(r_area);
                r_cnt <= mbae_pkg::MEAN_STEPS;
            end
        end
        if (i_cmd.mean_step || i_cmd.exp_step) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.mean_step && o_status.div_last) begin
            r_mean <= n_quo[mbae_pkg::MEAN_W-1:0];
        end
        if (i_cmd.exp_mul1) begin
            r_prod1 <= r_gain * r_exp;
            r_neg   <= r_mean > tgt_q;
            r_mag   <= (r_mean > tgt_q) ? r_mean - tgt_q : tgt_q - r_mean;
        end
        if (i_cmd.exp_mul2) begin
            r_prod <= r_prod1 * r_mag;
        end
        if (i_cmd.exp_ceil) begin
            r_c <= r_neg ? prod_up[mbae_pkg::PROD_W:mbae_pkg::GAIN_FRAC]
                         : {1'b0, r_prod[mbae_pkg::PROD_W-1:mbae_pkg::GAIN_FRAC]};
        end
        if (i_cmd.exp_chk && !o_status.exp_ovf) begin
            r_rem <= mbae_pkg::DIV_W'(r_c[mbae_pkg::EXP_QUO_W +: mbae_pkg::MEAN_W]);
            r_quo <= {r_c[mbae_pkg::EXP_QUO_W-1:0],
                      {(mbae_pkg::QUO_W - mbae_pkg::EXP_QUO_W){1'b0}}};
            r_div <= mbae_pkg::DIV_W'(r_mean);
            r_cnt <= mbae_pkg::EXP_STEPS;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.out_plain || i_cmd.out_upd) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_plain) begin
            r_out_exp  <= r_exp;
            r_out_upd  <= 1'b0;
            r_out_mean <= '0;
        end else if (i_cmd.out_upd) begin
            r_out_exp  <= r_exp;
            r_out_upd  <= 1'b1;
            r_out_mean <= r_mean;
        end
    end

    always_comb begin
        o_status.auto_due  = r_auto && (r_phase == '0);
        o_status.out_full  = r_out_valid;
        o_status.div_last  = r_cnt == mbae_pkg::CNT_W'(1);
        o_status.mean_zero = r_mean == '0;
        o_status.mean_sat  = {1'b0, r_sum} >= {r_area, 8'h00};
        o_status.exp_ovf   = r_c >= mbae_pkg::C_W'({r_mean, {mbae_pkg::EXP_QUO_W{1'b0}}});
    end

    assign o_out_valid    = r_out_valid;
    assign o_exposure_out = r_out_exp;
    assign o_was_updated  = r_out_upd;
    assign o_mean_level   = r_out_mean;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
import mbae_pkg::*;

typedef struct {
    logic [EXP_W-1:0]  exposure;
    logic              updated;
    logic [MEAN_W-1:0] mean;
} frame_result_t;

class exposure_tracker;
    logic              auto_en;
    logic [EXP_W-1:0]  manual;
    logic [TGT_W-1:0]  target;
    logic [GAIN_W-1:0] gain;
    logic              src_ir;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [EXP_W-1:0]  exposure;
    logic [PH_W-1:0]   frame_phase;
    logic [DIM_W-1:0]  col;
    logic [DIM_W-1:0]  row;
    logic [31:0]       pixel_sum;
    frame_result_t     pending_frames[$];
    int unsigned       errors;

    function new();
        auto_en     = 1'b1;
        manual      = EXP_RESET;
        target      = TGT_RESET;
        gain        = GAIN_RESET;
        src_ir      = 1'b0;
        width       = WIDTH_RESET;
        height      = HEIGHT_RESET;
        exposure    = EXP_RESET;
        frame_phase = '0;
        col         = '0;
        row         = '0;
        pixel_sum   = '0;
        errors      = 0;
    endfunction

    static function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function int unsigned pending();
        return pending_frames.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_AUTO_ENABLE:       auto_en = data[0];
            REG_MANUAL_EXPOSURE:   manual  = data[EXP_W-1:0];
            REG_TARGET_BRIGHTNESS: target  = data[TGT_W-1:0];
            REG_EXPOSURE_GAIN:     gain    = data[GAIN_W-1:0];
            REG_SOURCE_SELECT:     src_ir  = data[0];
            REG_FRAME_WIDTH:       width   = data[DIM_W-1:0];
            REG_FRAME_HEIGHT:      height  = data[DIM_W-1:0];
            default:               return;
        endcase
        if (!auto_en)
            exposure = EXP_W'(clamp(manual, EXP_MIN, EXP_MAX));
    endfunction

    function logic [EXP_W-1:0] next_exposure(logic [EXP_W-1:0] e, logic [MEAN_W-1:0] mean);
        longint num;
        longint den;
        longint q;
        if (mean == 0) return EXP_MAX;
        num = longint'(gain) * longint'(e) * (longint'(target) * 256 - longint'(mean));
        den = 64'sd4096 * longint'(mean);
        q = num / den;
        if ((num % den) != 0 && num < 0) q = q - 1;
        q = q + longint'(e);
        if (q < longint'(EXP_MIN)) return EXP_MIN;
        if (q > longint'(EXP_MAX)) return EXP_MAX;
        return EXP_W'(q);
    endfunction

    function void note_pixel(logic [PIX_W-1:0] ir, logic [PIX_W-1:0] color, logic last);
        logic [PIX_W-1:0] pix;
        int unsigned      w;
        int unsigned      half;
        logic [63:0]      m;
        frame_result_t    r;
        pix  = src_ir ? ir : color;
        w    = clamp(width, 1, MAX_WIDTH);
        half = clamp(height, 2, MAX_HEIGHT) / 2;
        if (row < half) begin
            pixel_sum = pixel_sum + 32'(pix);
            if (pixel_sum > 32'(SUM_MAX)) pixel_sum = 32'(SUM_MAX);
        end
        if (!last) begin
            col = col + 1'b1;
            if (col >= w) begin
                col = '0;
                if (row < MAX_HEIGHT) row = row + 1'b1;
            end
            return;
        end
        r.updated = 1'b0;
        r.mean    = '0;
        if (auto_en) begin
            if (frame_phase == 0) begin
                m = ({32'd0, pixel_sum} << 8) / (64'(w) * 64'(half));
                r.mean    = (m > 64'hFFFF) ? 16'hFFFF : m[MEAN_W-1:0];
                exposure  = next_exposure(exposure, r.mean);
                r.updated = 1'b1;
            end
            if (frame_phase == PHASE_LAST) frame_phase = '0;
            else frame_phase = frame_phase + 1'b1;
        end
        col       = '0;
        row       = '0;
        pixel_sum = '0;
        r.exposure = exposure;
        pending_frames.push_back(r);
    endfunction

    function void check_frame_result(logic [EXP_W-1:0] e, logic u, logic [MEAN_W-1:0] m);
        frame_result_t x;
        if (pending_frames.size() == 0) begin
            $display("%0t: unexpected result beat exposure %0d updated %0d mean %0d",
                     $time, e, u, m);
            errors++;
            return;
        end
        x = pending_frames.pop_front();
        if (x.exposure !== e) begin
            $display("%0t: exposure_out expected %0d got %0d", $time, x.exposure, e);
            errors++;
        end
        if (x.updated !== u) begin
            $display("%0t: was_updated expected %0d got %0d", $time, x.updated, u);
            errors++;
        end
        if (x.mean !== m) begin
            $display("%0t: mean_level expected %0d got %0d", $time, x.mean, m);
            errors++;
        end
    endfunction
endclass

module testbench;
    localparam int unsigned DRAIN_CYCLES = 48;
    localparam int unsigned CYCLE_LIMIT  = 1500000;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_FULL} pixel_fill_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic calm = 1'b0;
    int unsigned cycles = 0;
    int unsigned hold_left = 0;
    exposure_tracker tracker = new();

    mbae_pix_if pix();
    mbae_res_if res();
    mbae_cfg_if cfg();

    mean_brightness_auto_exposure dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .o_res   (res),
        .i_cfg   (cfg)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && res.valid && res.ready)
            tracker.check_frame_result(res.exposure_out, res.was_updated, res.mean_level);
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            res.ready <= 1'b0;
        end else begin
            res.ready <= 1'b1;
            if ($urandom_range(0, 4) == 0) hold_left = pick_gap();
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] ir, input logic [PIX_W-1:0] color,
                              input logic last);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            pix.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix.valid       <= 1'b1;
        pix.ir_pixel    <= ir;
        pix.color_pixel <= color;
        pix.frame_end   <= last;
        do @(posedge i_clk); while (!pix.ready);
        tracker.note_pixel(ir, color, last);
    endtask

    task automatic send_frame(input int unsigned len, input pixel_fill_t fill);
        logic [PIX_W-1:0] a;
        logic [PIX_W-1:0] b;
        for (int unsigned k = 0; k < len; k++) begin
            case (fill)
                FILL_ZERO: begin a = '0; b = '0; end
                FILL_FULL: begin a = '1; b = '1; end
                default:   begin
                    a = PIX_W'($urandom_range(0, 255));
                    b = PIX_W'($urandom_range(0, 255));
                end
            endcase
            send_pixel(a, b, k == len - 1);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do @(posedge i_clk); while (!cfg.ready);
        tracker.write_reg(idx, data);
        cfg.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic settle();
        pix.valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic shuffle_settings();
        logic [CFG_DATA_W-1:0] data;
        bit wide;
        for (int i = 0; i < 7; i++) begin
            if ($urandom_range(0, 2) != 0) begin
                wide = ($urandom_range(0, 3) == 0);
                case (t_reg_idx'(i))
                    REG_AUTO_ENABLE:
                        data = CFG_DATA_W'($urandom_range(0, 5) != 0);
                    REG_MANUAL_EXPOSURE:   data = CFG_DATA_W'($urandom_range(0, 10000));
                    REG_TARGET_BRIGHTNESS: data = CFG_DATA_W'($urandom_range(0, 255));
                    REG_EXPOSURE_GAIN:     data = CFG_DATA_W'($urandom_range(0, 65535));
                    REG_SOURCE_SELECT:     data = CFG_DATA_W'($urandom_range(0, 1));
                    REG_FRAME_WIDTH:       data = CFG_DATA_W'($urandom_range(1, 12));
                    default:               data = CFG_DATA_W'($urandom_range(2, 12));
                endcase
                if (wide) data = CFG_DATA_W'($urandom_range(0, 65535));
                write_reg(CFG_IDX_W'(i), data);
            end
        end
        if ($urandom_range(0, 7) == 0)
            write_reg(REG_UNMAPPED, CFG_DATA_W'($urandom_range(0, 65535)));
    endtask

    initial begin
        logic [PIX_W-1:0] a;
        logic [PIX_W-1:0] b;
        int unsigned r;

        pix.valid       = 1'b0;
        pix.ir_pixel    = '0;
        pix.color_pixel = '0;
        pix.frame_end   = 1'b0;
        cfg.valid       = 1'b0;
        cfg.index       = '0;
        cfg.data        = '0;
        res.ready       = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_frame(3, FILL_FULL);
        settle();
        write_reg(REG_FRAME_WIDTH, 16'd2);
        write_reg(REG_FRAME_HEIGHT, 16'd2);
        write_reg(REG_SOURCE_SELECT, 16'd1);
        repeat (4) send_frame(1, FILL_RANDOM);
        send_frame(2, FILL_ZERO);
        repeat (4) send_frame(1, FILL_RANDOM);
        send_frame(2, FILL_FULL);
        settle();
        write_reg(REG_EXPOSURE_GAIN, 16'hFFFF);
        write_reg(REG_TARGET_BRIGHTNESS, 16'd255);
        write_reg(REG_FRAME_WIDTH, 16'd0);
        write_reg(REG_FRAME_HEIGHT, 16'd1);
        write_reg(REG_SOURCE_SELECT, 16'd0);
        repeat (4) send_frame(1, FILL_RANDOM);
        send_frame(2, FILL_FULL);
        settle();
        write_reg(REG_EXPOSURE_GAIN, 16'd0);
        write_reg(REG_TARGET_BRIGHTNESS, 16'd0);
        write_reg(REG_AUTO_ENABLE, 16'd0);
        write_reg(REG_MANUAL_EXPOSURE, 16'd0);
        send_frame(1, FILL_RANDOM);
        settle();
        write_reg(REG_MANUAL_EXPOSURE, 16'h3FFF);
        send_frame(1, FILL_RANDOM);
        settle();
        write_reg(REG_AUTO_ENABLE, 16'd1);
        write_reg(REG_EXPOSURE_GAIN, 16'd4096);
        write_reg(REG_TARGET_BRIGHTNESS, 16'd128);
        write_reg(REG_FRAME_WIDTH, 16'h1FFF);
        write_reg(REG_FRAME_HEIGHT, 16'h1FFF);
        write_reg(REG_UNMAPPED, 16'hFFFF);
        send_frame(1, FILL_RANDOM);
        settle();

        for (int ph = 0; ph < 10; ph++) begin
            calm = ($urandom_range(0, 3) == 0);
            shuffle_settings();
            for (int k = 0; k < 70; k++) begin
                r = $urandom_range(0, 9);
                a = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom_range(0, 255));
                r = $urandom_range(0, 9);
                b = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom_range(0, 255));
                send_pixel(a, b, $urandom_range(0, 5) == 0);
            end
            settle();
        end

        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/mbae_pkg.sv
hw/rtl/mbae_if.sv
hw/rtl/mbae_ctrl.sv
hw/rtl/mbae_dp.sv
hw/rtl/mean_brightness_auto_exposure.sv
tb/testbench.sv
